>>> hdl/sxot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared/exclusive owner table package
// Word types, action codes and default sizes used across the owner table.
// ----------------------------------------------------------------------------
package sxot_pkg;

  // Default table size and stored id width.
  localparam int MaxOwnerSlotsDef = 16;
  localparam int IdBitsDef        = 16;

  // Fixed field widths of the words on the ports.
  localparam int ReqW   = 16;
  localparam int CountW = 5;

  // Action codes carried in the input word.
  typedef enum logic [1:0] {
    ACT_GET_SHARED = 2'd0,
    ACT_GET_EXCL   = 2'd1,
    ACT_FREE       = 2'd2,
    ACT_CHECK      = 2'd3
  } sxot_action_e;

  // Input word: one request.
  typedef struct packed {
    logic [1:0]      action;
    logic [ReqW-1:0] requester;
  } sxot_in_t;

  // Output word: one result.
  typedef struct packed {
    logic              outcome;
    logic [CountW-1:0] owner_count;
    logic              exclusive_held;
  } sxot_out_t;

endpackage

>>> hdl/sxot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Owner id memory
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module sxot_mem #(
  parameter int Depth = 16,
  parameter int Width = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sxot_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Owner table sequencer
// Holds the owner count and exclusive flag, scans the id memory for a
// requester, shifts the list down after a free and registers the result word.
// ----------------------------------------------------------------------------
module sxot_ctrl #(
  parameter int MAX_OWNER_SLOTS = 16,
  parameter int ID_BITS         = 16,
  parameter int IdxW            = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sxot_pkg::sxot_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sxot_pkg::sxot_out_t out_word_o,
  output logic                mem_we_o,
  output logic [IdxW-1:0]     mem_waddr_o,
  output logic [ID_BITS-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [IdxW-1:0]     mem_raddr_o,
  input  logic [ID_BITS-1:0]  mem_rdata_i
);

  import sxot_pkg::*;

  localparam int CntW = $clog2(MAX_OWNER_SLOTS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_OWNER_SLOTS);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  sxot_action_e     op_q, op_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [CntW-1:0]  total_q, total_d;
  logic             excl_q, excl_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [CntW-1:0]  src_q, src_d;
  logic             shv_q, shv_d;
  logic [IdxW-1:0]  wr_idx_q, wr_idx_d;
  logic             outcome_q, outcome_d;
  logic             out_valid_q, out_valid_d;
  sxot_out_t        out_q, out_d;

  logic [ID_BITS-1:0] in_id;
  logic               hit;
  logic               accept;

  assign in_id      = ID_BITS'(in_word_i.requester);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign hit        = cmp_valid_q && (mem_rdata_i == id_q);

  // Next state, memory requests and result formation.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    total_d     = total_q;
    excl_d      = excl_q;
    scan_d      = scan_q;
    cmp_valid_d = cmp_valid_q;
    cmp_idx_d   = cmp_idx_q;
    src_d       = src_q;
    shv_d       = shv_q;
    wr_idx_d    = wr_idx_q;
    outcome_d   = outcome_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = total_q[IdxW-1:0];
    mem_wdata_o = in_id;
    mem_re_o    = 1'b0;
    mem_raddr_o = scan_q[IdxW-1:0];

    // The downstream side takes the waiting word.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          id_d = in_id;
          op_d = sxot_action_e'(in_word_i.action);
          unique case (sxot_action_e'(in_word_i.action)) inside
            ACT_GET_SHARED: begin
              // Append unless held exclusively or the table is full.
              if (!excl_q && (total_q < MaxCnt)) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = total_q[IdxW-1:0];
                total_d     = total_q + OneCnt;
                outcome_d   = 1'b0;
              end else begin
                outcome_d = 1'b1;
              end
              state_d = ST_DONE;
            end
            ACT_GET_EXCL: begin
              // Only granted when nobody owns the device.
              if (total_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                total_d     = OneCnt;
                excl_d      = 1'b1;
                outcome_d   = 1'b0;
              end else begin
                outcome_d = 1'b1;
              end
              state_d = ST_DONE;
            end
            ACT_FREE, ACT_CHECK: begin
              scan_d      = '0;
              cmp_valid_d = 1'b0;
              state_d     = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Pipelined scan: issue one read per cycle, compare the previous one.
        if (hit) begin
          cmp_valid_d = 1'b0;
          if (op_q == ACT_FREE) begin
            src_d   = CntW'(cmp_idx_q) + OneCnt;
            shv_d   = 1'b0;
            state_d = ST_SHIFT;
          end else begin
            outcome_d = 1'b0;
            state_d   = ST_DONE;
          end
        end else if (scan_q < total_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_q[IdxW-1:0];
          cmp_valid_d = 1'b1;
          cmp_idx_d   = scan_q[IdxW-1:0];
          scan_d      = scan_q + OneCnt;
        end else begin
          cmp_valid_d = 1'b0;
          outcome_d   = 1'b1;
          state_d     = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // Each entry above the freed slot moves down by one.
        if (shv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_idx_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (src_q < total_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = src_q[IdxW-1:0];
          wr_idx_d    = IdxW'(src_q - OneCnt);
          shv_d       = 1'b1;
          src_d       = src_q + OneCnt;
        end else begin
          shv_d = 1'b0;
          if (!shv_q) begin
            total_d   = total_q - OneCnt;
            excl_d    = 1'b0;
            outcome_d = 1'b0;
            state_d   = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // Load the result word once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.outcome        = outcome_q;
          out_d.owner_count    = CountW'(total_q);
          out_d.exclusive_held = excl_q;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ACT_GET_SHARED;
      id_q        <= '0;
      total_q     <= '0;
      excl_q      <= 1'b0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      src_q       <= '0;
      shv_q       <= 1'b0;
      wr_idx_q    <= '0;
      outcome_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      id_q        <= id_d;
      total_q     <= total_d;
      excl_q      <= excl_d;
      scan_q      <= scan_d;
      cmp_valid_q <= cmp_valid_d;
      cmp_idx_q   <= cmp_idx_d;
      src_q       <= src_d;
      shv_q       <= shv_d;
      wr_idx_q    <= wr_idx_d;
      outcome_q   <= outcome_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Exclusive ownership always means exactly one listed owner.
  assert property (@(posedge clk_i) disable iff (!rst_ni) excl_q |-> (total_q == OneCnt))
    else $error("exclusive flag set without a single owner");

  // The owner count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= MaxCnt)
    else $error("owner count above table size");

  // A granted shared get adds exactly one owner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && (in_word_i.action == ACT_GET_SHARED) && !excl_q && (total_q < MaxCnt))
      |=> (total_q == $past(total_q) + OneCnt))
    else $error("shared get did not add an owner");

  // Compare and shift pipelines only run inside their own phases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmp_valid_q |-> (state_q == ST_SCAN)) and (shv_q |-> (state_q == ST_SHIFT)))
    else $error("memory read pipeline active outside its phase");

endmodule

>>> hdl/shared_exclusive_owner_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared/exclusive owner table
// Records which requesters own a shared device and whether it is held
// exclusively; answers get, free and check requests one word at a time.
// ----------------------------------------------------------------------------
// The table handles one request at a time, with the owner ids kept in a
// synchronous RAM that has one write port and one read port. A granted
// shared or exclusive get writes the RAM when the request is taken, and no
// get needs a scan. A check scans the listed owners, reading one entry per
// cycle. A free scans the same way and stops at the first match, then a
// shift-down pass moves each entry above it one slot down, one entry per
// cycle through the read and write ports. The result register lets a new
// request be taken while the previous result still waits downstream. No
// clearing pass is needed after reset.
module shared_exclusive_owner_table_top #(
  parameter int MAX_OWNER_SLOTS = sxot_pkg::MaxOwnerSlotsDef,
  parameter int ID_BITS         = sxot_pkg::IdBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sxot_pkg::sxot_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sxot_pkg::sxot_out_t out_word_o
);

  import sxot_pkg::*;

  localparam int IdxW = (MAX_OWNER_SLOTS > 1) ? $clog2(MAX_OWNER_SLOTS) : 1;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic               mem_re;
  logic [IdxW-1:0]    mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;

  // Sequencer and state registers.
  sxot_ctrl #(
    .MAX_OWNER_SLOTS(MAX_OWNER_SLOTS),
    .ID_BITS        (ID_BITS),
    .IdxW           (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Owner id storage.
  sxot_mem #(
    .Depth(MAX_OWNER_SLOTS),
    .Width(ID_BITS),
    .AddrW(IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule
